// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int unsigned PcW   = 3;
  localparam int unsigned CfgIw = 3;
  localparam int unsigned CfgDw = 18;
  localparam int unsigned AccW  = 40;
  localparam int unsigned YW    = 20;

  localparam logic [CfgIw-1:0] RegSpikeThreshold = 3'd0;
  localparam logic [CfgIw-1:0] RegSpikeLimit     = 3'd1;
  localparam logic [CfgIw-1:0] RegCoefB0         = 3'd2;
  localparam logic [CfgIw-1:0] RegCoefB1         = 3'd3;
  localparam logic [CfgIw-1:0] RegCoefA1         = 3'd4;
  localparam logic [CfgIw-1:0] RegScaleFactor    = 3'd5;
  localparam logic [CfgIw-1:0] RegGroundLimit    = 3'd6;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    MA_B0,
    MA_B1,
    MA_A1,
    MA_SCALE
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_X,
    MB_PS,
    MB_YP
  } mul_b_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    acc_op_e        acc_op;
    mul_a_e         mul_a;
    mul_b_e         mul_b;
    logic           spike;
    logic           round;
    logic           done;
    logic           jmp_nonpos;
    logic [PcW-1:0] jmp_target;
  } ctrl_t;

  typedef struct packed {
    logic y_nonpos;
  } stat_t;

  typedef struct packed {
    logic [15:0]        threshold;
    logic [2:0]         limit;
    logic signed [17:0] b0;
    logic signed [17:0] b1;
    logic signed [17:0] a1;
    logic [15:0]        scale;
    logic [14:0]        ground;
  } cfg_t;

  typedef struct packed {
    logic [15:0] used_sample;
    logic        spike_replaced;
    logic        near_ground;
    logic [14:0] altitude;
  } res_t;

  localparam ctrl_t CtrlNop = '{
    acc_op: ACC_NONE, mul_a: MA_B0, mul_b: MB_X, spike: 1'b0, round: 1'b0,
    done: 1'b0, jmp_nonpos: 1'b0, jmp_target: '0
  };

  // microcode program, one control word per step
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = CtrlNop;
    case (pc)
      3'd0: w.spike = 1'b1;
      3'd1: begin
        w.acc_op = ACC_LOAD;
        w.mul_a  = MA_B0;
        w.mul_b  = MB_X;
      end
      3'd2: begin
        w.acc_op = ACC_ADD;
        w.mul_a  = MA_B1;
        w.mul_b  = MB_PS;
      end
      3'd3: begin
        w.acc_op = ACC_SUB;
        w.mul_a  = MA_A1;
        w.mul_b  = MB_YP;
      end
      3'd4: begin
        w.round      = 1'b1;
        w.jmp_nonpos = 1'b1;
        w.jmp_target = 3'd6;
      end
      3'd5: begin
        w.acc_op = ACC_LOAD;
        w.mul_a  = MA_SCALE;
        w.mul_b  = MB_YP;
      end
      3'd6: w.done = 1'b1;
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ssr_sequencer.sv =====
module ssr_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          stall_i,
  input  ssr_pkg::stat_t stat_i,
  output logic          idle_o,
  output logic          exec_o,
  output ssr_pkg::ctrl_t ctrl_o
);

  ssr_pkg::seq_state_e state_q, state_d;
  logic [ssr_pkg::PcW-1:0] pc_q, pc_d;

  assign ctrl_o = ssr_pkg::ucode(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssr_pkg::SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    idle_o  = 1'b0;
    exec_o  = 1'b0;
    case (state_q)
      ssr_pkg::SEQ_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          state_d = ssr_pkg::SEQ_RUN;
          pc_d    = '0;
        end
      end
      ssr_pkg::SEQ_RUN: begin
        if (!stall_i) begin
          exec_o = 1'b1;
          if (ctrl_o.done) begin
            state_d = ssr_pkg::SEQ_IDLE;
          end else if (ctrl_o.jmp_nonpos && stat_i.y_nonpos) begin
            pc_d = ctrl_o.jmp_target;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: state_d = ssr_pkg::SEQ_IDLE;
    endcase
  end

endmodule

// ===== src/ssr_datapath.sv =====
module ssr_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [15:0]    sample_i,
  input  logic           exec_i,
  input  ssr_pkg::ctrl_t ctrl_i,
  input  ssr_pkg::cfg_t  cfg_i,
  output ssr_pkg::stat_t stat_o,
  output ssr_pkg::res_t  res_o
);

  logic [15:0]                       in_q;
  logic [15:0]                       x_q;
  logic                              rep_q;
  logic                              zero_q;
  logic signed [ssr_pkg::AccW-1:0]   acc_q, acc_d;
  // filter state
  logic [15:0]                       ps_q;
  logic signed [ssr_pkg::YW-1:0]     yp_q;
  logic [2:0]                        cnt_q;

  // spike test at full width
  logic signed [21:0] xs, yp_ext, thr_ext, hi, lo;
  logic               is_spike, replace;
  logic [15:0]        clamp;

  assign xs      = signed'({6'b0, in_q});
  assign yp_ext  = 22'(yp_q);
  assign thr_ext = signed'({6'b0, cfg_i.threshold});
  assign hi      = yp_ext + thr_ext;
  assign lo      = yp_ext - thr_ext;
  assign is_spike = (xs > hi) || (xs < lo);
  assign replace  = is_spike && (cnt_q < cfg_i.limit);

  always_comb begin
    if (yp_q[ssr_pkg::YW-1]) begin
      clamp = '0;
    end else if (yp_q > 20'sd65535) begin
      clamp = 16'hffff;
    end else begin
      clamp = yp_q[15:0];
    end
  end

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [38:0] prod;
  logic signed [ssr_pkg::AccW-1:0] prod_ext;

  always_comb begin
    case (ctrl_i.mul_a)
      ssr_pkg::MA_B0:    mul_a = cfg_i.b0;
      ssr_pkg::MA_B1:    mul_a = cfg_i.b1;
      ssr_pkg::MA_A1:    mul_a = cfg_i.a1;
      ssr_pkg::MA_SCALE: mul_a = signed'({2'b00, cfg_i.scale});
      default:           mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      ssr_pkg::MB_X:  mul_b = signed'({5'b0, x_q});
      ssr_pkg::MB_PS: mul_b = signed'({5'b0, ps_q});
      ssr_pkg::MB_YP: mul_b = 21'(yp_q);
      default:        mul_b = '0;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ssr_pkg::AccW'(prod);

  always_comb begin
    case (ctrl_i.acc_op)
      ssr_pkg::ACC_LOAD: acc_d = prod_ext;
      ssr_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      ssr_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  // round half up, then saturate to 20 bits
  logic signed [ssr_pkg::AccW-1:0] rnd;
  logic signed [23:0]              sh;
  logic signed [ssr_pkg::YW-1:0]   y_new;

  assign rnd = acc_q + 40'sd32768;
  assign sh  = signed'(rnd[ssr_pkg::AccW-1:16]);

  always_comb begin
    if (sh > 24'sd524287) begin
      y_new = 20'sd524287;
    end else if (sh < -24'sd524288) begin
      y_new = -20'sd524288;
    end else begin
      y_new = sh[ssr_pkg::YW-1:0];
    end
  end

  assign stat_o.y_nonpos = y_new[ssr_pkg::YW-1] || (y_new == '0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= sample_i;
    end
    if (exec_i) begin
      acc_q <= acc_d;
      if (ctrl_i.spike) begin
        x_q   <= replace ? clamp : in_q;
        rep_q <= replace;
      end
      if (ctrl_i.round) begin
        zero_q <= stat_o.y_nonpos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= '0;
      yp_q  <= '0;
      cnt_q <= '0;
    end else if (exec_i) begin
      if (ctrl_i.spike) begin
        cnt_q <= replace ? cnt_q + 1'b1 : 3'd0;
      end
      if (ctrl_i.round) begin
        ps_q <= x_q;
        yp_q <= y_new;
      end
    end
  end

  // scaled altitude, accumulator holds y * scale here
  logic [14:0] alt;

  always_comb begin
    if (zero_q) begin
      alt = '0;
    end else if (|acc_q[ssr_pkg::AccW-1:31]) begin
      alt = 15'h7fff;
    end else begin
      alt = acc_q[30:16];
    end
  end

  assign res_o.altitude       = alt;
  assign res_o.near_ground    = (alt != '0) && (alt < cfg_i.ground);
  assign res_o.spike_replaced = rep_q;
  assign res_o.used_sample    = x_q;

endmodule

// ===== src/sonar_spike_reject_iir_filter.sv =====
// each sample is taken while the sequencer is idle and then runs the 7-step microcode program
// that computes the three filter taps and the scaling through one shared 18x21 multiplier;
// the scaling step is skipped when the filtered value is not positive; no new sample is
// accepted until the program finishes, and a result still waiting on the output holds the last step
// reset: filter history, spike count and handshake state clear; registers take their defaults
module sonar_spike_reject_iir_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,  // pulse_count
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // altitude[14:0], near_ground[15], spike_replaced[16], used_sample[32:17], zero pad
  output logic [39:0]                 m_axis_tdata_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ssr_pkg::CfgIw-1:0]   cfg_index_i,
  input  logic [ssr_pkg::CfgDw-1:0]   cfg_data_i
);

  ssr_pkg::cfg_t  cfg_q;
  ssr_pkg::ctrl_t ctrl;
  ssr_pkg::stat_t stat;
  ssr_pkg::res_t  res;
  ssr_pkg::res_t  out_q;
  logic           out_valid_q;
  logic           idle, exec, start, stall, load_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= 16'd3000;
      cfg_q.limit     <= 3'd5;
      cfg_q.b0        <= 18'sd65536;
      cfg_q.b1        <= '0;
      cfg_q.a1        <= '0;
      cfg_q.scale     <= 16'd2772;
      cfg_q.ground    <= 15'd51;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssr_pkg::RegSpikeThreshold: cfg_q.threshold <= cfg_data_i[15:0];
        ssr_pkg::RegSpikeLimit:     cfg_q.limit     <= cfg_data_i[2:0];
        ssr_pkg::RegCoefB0:         cfg_q.b0        <= signed'(cfg_data_i);
        ssr_pkg::RegCoefB1:         cfg_q.b1        <= signed'(cfg_data_i);
        ssr_pkg::RegCoefA1:         cfg_q.a1        <= signed'(cfg_data_i);
        ssr_pkg::RegScaleFactor:    cfg_q.scale     <= cfg_data_i[15:0];
        ssr_pkg::RegGroundLimit:    cfg_q.ground    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  // hold the final step while the previous result still waits
  assign stall           = ctrl.done && out_valid_q && !m_axis_tready_i;
  assign load_out        = exec && ctrl.done;

  ssr_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stall_i (stall),
    .stat_i  (stat),
    .idle_o  (idle),
    .exec_o  (exec),
    .ctrl_o  (ctrl)
  );

  ssr_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (s_axis_tdata_i),
    .exec_i   (exec),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .stat_o   (stat),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q};

endmodule

// ===== tb/tb_sonar_spike_reject_iir_filter.sv =====
`timescale 1ns / 100ps

module tb_sonar_spike_reject_iir_filter;
  import ssr_pkg::*;

  localparam logic [CfgIw-1:0] RegNone = 3'd7;  // outside the register map
  localparam int IdlePct    = 36;
  localparam int MaxReports = 10;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [15:0]       s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [39:0]       m_axis_tdata_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIw-1:0]  cfg_index_i;
  logic [CfgDw-1:0]  cfg_data_i;

  // shadow of the filter state and its registers
  cfg_t                 shadow_cfg;
  logic [15:0]          last_used;
  logic signed [YW-1:0] last_y;
  logic [2:0]           spike_run;
  res_t                 pending_readings[$];

  bit idling_on   = 1'b1;
  int rx_hold     = 0;
  int n_mismatch  = 0;
  int n_pulses    = 0;
  int n_readings  = 0;
  int n_replaced  = 0;
  int n_near      = 0;
  int n_writes    = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  sonar_spike_reject_iir_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  function automatic cfg_t make_cfg(input int thr, lim, b0, b1, a1, scale, ground);
    cfg_t c;
    c.threshold = thr[15:0];
    c.limit     = lim[2:0];
    c.b0        = b0[17:0];
    c.b1        = b1[17:0];
    c.a1        = a1[17:0];
    c.scale     = scale[15:0];
    c.ground    = ground[14:0];
    return c;
  endfunction

  function automatic void shadow_write(input logic [CfgIw-1:0] idx,
                                       input logic [CfgDw-1:0] val);
    case (idx)
      RegSpikeThreshold: shadow_cfg.threshold = val[15:0];
      RegSpikeLimit:     shadow_cfg.limit     = val[2:0];
      RegCoefB0:         shadow_cfg.b0        = val;
      RegCoefB1:         shadow_cfg.b1        = val;
      RegCoefA1:         shadow_cfg.a1        = val;
      RegScaleFactor:    shadow_cfg.scale     = val[15:0];
      RegGroundLimit:    shadow_cfg.ground    = val[14:0];
      default: ;
    endcase
  endfunction

  // spike test, filter step and scaling for one pulse; advances the shadow state
  function automatic res_t predict_altitude(input logic [15:0] pulse);
    longint x, yp, thr, acc, y, alt;
    res_t   r;
    x   = pulse;
    yp  = last_y;
    thr = shadow_cfg.threshold;
    r.spike_replaced = 1'b0;
    if ((x > yp + thr || x < yp - thr) && spike_run < shadow_cfg.limit) begin
      spike_run = spike_run + 3'd1;
      x = (yp < 0) ? 0 : ((yp > 65535) ? 65535 : yp);
      r.spike_replaced = 1'b1;
    end else begin
      spike_run = '0;
    end
    acc = longint'($signed(shadow_cfg.b0)) * x
        + longint'($signed(shadow_cfg.b1)) * longint'(last_used)
        - longint'($signed(shadow_cfg.a1)) * yp;
    // round half up, then clamp to the 20-bit signed range
    y = (acc + 32768) >>> 16;
    if (y > 524287) y = 524287;
    if (y < -524288) y = -524288;
    last_used = x[15:0];
    last_y    = y[YW-1:0];
    if (y <= 0) begin
      alt = 0;
    end else begin
      alt = (y * longint'(shadow_cfg.scale)) >>> 16;
      if (alt > 32767) alt = 32767;
    end
    r.altitude    = alt[14:0];
    r.near_ground = (alt != 0) && (alt < longint'(shadow_cfg.ground));
    r.used_sample = x[15:0];
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    n_mismatch++;
    if (n_mismatch <= MaxReports)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endfunction

  task automatic check_reading(input logic [39:0] beat);
    res_t want;
    res_t got;
    got = beat[32:0];
    n_readings++;
    if (got.spike_replaced) n_replaced++;
    if (got.near_ground) n_near++;
    if (pending_readings.size() == 0) begin
      note_mismatch("unexpected reading, altitude", -1, got.altitude);
      return;
    end
    want = pending_readings.pop_front();
    if (got.altitude != want.altitude)
      note_mismatch("altitude", want.altitude, got.altitude);
    if (got.near_ground != want.near_ground)
      note_mismatch("near_ground", want.near_ground, got.near_ground);
    if (got.spike_replaced != want.spike_replaced)
      note_mismatch("spike_replaced", want.spike_replaced, got.spike_replaced);
    if (got.used_sample != want.used_sample)
      note_mismatch("used_sample", want.used_sample, got.used_sample);
    if (beat[39:33] != '0)
      note_mismatch("pad bits", 0, beat[39:33]);
  endtask

  // result side: check, then pick tready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_reading(m_axis_tdata_o);
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !idling_on || ($urandom_range(99) >= IdlePct);
    end
  end

  // tvalid stays high on return so back-to-back requests need no extra edge
  task automatic send_pulse(input logic [15:0] pulse);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(99) < IdlePct) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pulse;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_readings.push_back(predict_altitude(pulse));
    n_pulses++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIw-1:0] idx, input logic [CfgDw-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_write(idx, val);
    n_writes++;
  endtask

  // writes all registers; junk fills the bits above each register's width
  task automatic apply_cfg(input cfg_t c, input bit junk);
    logic [CfgDw-1:0] hi;
    hi = junk ? CfgDw'($urandom) : '0;
    cfg_put(RegSpikeThreshold, {hi[CfgDw-1:16], c.threshold});
    cfg_put(RegSpikeLimit,     {hi[CfgDw-1:3], c.limit});
    cfg_put(RegCoefB0,         c.b0);
    cfg_put(RegCoefB1,         c.b1);
    cfg_put(RegCoefA1,         c.a1);
    cfg_put(RegScaleFactor,    {hi[CfgDw-1:16], c.scale});
    cfg_put(RegGroundLimit,    {hi[CfgDw-1:15], c.ground});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cfg(input cfg_t c);
    wait_idle();
    apply_cfg(c, 1'b0);
  endtask

  // mostly a slow walk with spike bursts on top, some plain noise
  task automatic run_pulses(input int n);
    int level, d, burst, v;
    level = $urandom_range(65535);
    burst = 0;
    repeat (n) begin
      d = int'(shadow_cfg.threshold) / 2 + 20;
      if (burst == 0 && $urandom_range(99) < 8) burst = $urandom_range(1, 8);
      if (burst > 0) begin
        burst--;
        v = int'(shadow_cfg.threshold) + 1 + int'($urandom_range(20000));
        v = $urandom_range(1) ? level + v : level - v;
      end else if ($urandom_range(99) < 10) begin
        v = $urandom_range(65535);
      end else begin
        level = level + int'($urandom_range(2 * d)) - d;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        v = level;
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      send_pulse(v[15:0]);
    end
  endtask

  task automatic test_reset_values();
    // near-ground edge sits around 1205 counts with the default scale
    send_pulse(16'd0);
    send_pulse(16'd2000);
    send_pulse(16'd1205);
    send_pulse(16'd1206);
    send_pulse(16'd24);
    send_pulse(16'd23);
    send_pulse(16'd65535);
    send_pulse(16'd65535);
  endtask

  task automatic test_spike_limits();
    set_cfg(make_cfg(0, 2, 65536, 0, 0, 2772, 51));
    repeat (3) send_pulse(16'd100);
    set_cfg(make_cfg(0, 0, 65536, 0, 0, 2772, 51));
    send_pulse(16'd0);
  endtask

  task automatic test_replacement_clamp();
    // push the filter above 16 bits, then below zero, and replace a spike each time
    set_cfg(make_cfg(100, 0, 131071, 0, 0, 2772, 51));
    send_pulse(16'd40000);
    set_cfg(make_cfg(100, 1, 131071, 0, 0, 2772, 51));
    send_pulse(16'd100);
    set_cfg(make_cfg(100, 0, -131072, 0, 0, 2772, 51));
    send_pulse(16'd40000);
    set_cfg(make_cfg(100, 1, -131072, 0, 0, 2772, 51));
    send_pulse(16'd5);
  endtask

  task automatic test_saturation_rounding();
    set_cfg(make_cfg(65535, 0, 131071, 131071, -131072, 65535, 32767));
    repeat (3) send_pulse(16'hFFFF);
    set_cfg(make_cfg(65535, 0, -131072, -131072, 131071, 65535, 32767));
    repeat (2) send_pulse(16'hFFFF);
    // halves round toward plus infinity
    set_cfg(make_cfg(65535, 0, -32768, 0, 0, 65535, 32767));
    send_pulse(16'd1);
    send_pulse(16'd3);
    set_cfg(make_cfg(65535, 0, 32768, 0, 0, 65535, 32767));
    send_pulse(16'd1);
    send_pulse(16'd3);
  endtask

  task automatic test_unmapped_register();
    wait_idle();
    cfg_put(RegNone, '1);
    cfg_valid_i <= 1'b0;
    send_pulse(16'd5000);
    send_pulse(16'd5100);
  endtask

  task automatic test_backpressure();
    set_cfg(make_cfg(3000, 5, 65536, 0, 0, 2772, 51));
    rx_hold = 150;
    repeat (10) send_pulse(16'($urandom_range(2000, 9000)));
    wait_idle();
  endtask

  task automatic test_random_settings();
    cfg_t c;
    int   p, b0, b1;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) begin
        idling_on = 1'b0;
        apply_cfg(make_cfg(3000, 5, 65536, 0, 0, 2772, 51), 1'b0);
        run_pulses(60);
        idling_on = 1'b1;
      end else if (ph < 4) begin
        // unity dc gain with a random pole
        p  = $urandom_range(60000);
        b0 = 65536 - p;
        b1 = $urandom_range(b0);
        c  = make_cfg($urandom_range(50, 8000), $urandom_range(7), b0 - b1, b1, -p,
                      $urandom_range(65535), $urandom_range(32767));
        apply_cfg(c, 1'b1);
        run_pulses(50);
      end else if (ph < 6) begin
        c = make_cfg($urandom_range(65535), $urandom_range(7),
                     int'($urandom_range(262143)) - 131072,
                     int'($urandom_range(262143)) - 131072,
                     int'($urandom_range(262143)) - 131072,
                     $urandom_range(65535), $urandom_range(32767));
        apply_cfg(c, 1'b1);
        run_pulses(50);
      end else if (ph == 6) begin
        apply_cfg(make_cfg(65535, 7, 131071, 131071, 131071, 65535, 32767), 1'b1);
        run_pulses(25);
      end else begin
        apply_cfg(make_cfg(0, 0, -131072, -131072, -131072, 0, 0), 1'b0);
        run_pulses(25);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = RegSpikeThreshold;
    cfg_data_i      = '0;
    shadow_cfg      = make_cfg(3000, 5, 65536, 0, 0, 2772, 51);
    last_used       = '0;
    last_y          = '0;
    spike_run       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_spike_limits();
    test_replacement_clamp();
    test_saturation_rounding();
    test_unmapped_register();
    test_backpressure();
    test_random_settings();
    wait_idle();

    $display("sent %0d pulses over %0d register writes, %0d readings compared",
             n_pulses, n_writes, n_readings);
    $display("readings with spike replaced: %0d, near ground: %0d, mismatches: %0d",
             n_replaced, n_near, n_mismatch);
    if (n_mismatch == 0 && pending_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d readings outstanding", pending_readings.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssr_pkg.sv
src/ssr_sequencer.sv
src/ssr_datapath.sv
src/sonar_spike_reject_iir_filter.sv
tb/tb_sonar_spike_reject_iir_filter.sv
